/* rtl/core/confusion_matrix_accuracy_macros.svh */
// Assertion macros for the confusion matrix accuracy block.
// Used by rtl/core/confusion_matrix_accuracy.sv; no other dependencies.
`ifndef CONFUSION_MATRIX_ACCURACY_MACROS_SVH
`define CONFUSION_MATRIX_ACCURACY_MACROS_SVH

// same-cycle implication
`define CMA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("confusion_matrix_accuracy: same-cycle check failed");

// next-cycle implication
`define CMA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("confusion_matrix_accuracy: next-cycle check failed");

`endif

/* rtl/core/cma_pkg.sv */
// Shared types and constants for the confusion matrix accuracy block.
// No dependencies; used by cma_ram users and the top level.
package cma_pkg;

   localparam int MAX_CLASSES = 16;
   localparam int IDX_W       = $clog2(MAX_CLASSES);
   localparam int DEPTH       = MAX_CLASSES * MAX_CLASSES;
   localparam int ADDR_W      = $clog2(DEPTH);
   localparam int COUNT_BITS  = 32;
   localparam int CFG_W       = 5;
   localparam int AMT_W       = 16;
   localparam int ROW_W       = 36;
   localparam int TOT_W       = 40;
   localparam int Q_W         = 17;
   localparam int KAP_W       = 18;
   localparam int PE_W        = 38;
   localparam int DIV_N_W     = 56;
   localparam int DIV_CNT_W   = 6;
   localparam int SQ_W        = 32;
   localparam int SQ_CNT_W    = 4;

   localparam logic [CFG_W-1:0]      CLASSES_RESET = CFG_W'(MAX_CLASSES);
   localparam logic [COUNT_BITS-1:0] CELL_MAX      = '1;
   localparam logic [Q_W-1:0]        ONE_Q16       = 17'h10000;
   localparam logic [DIV_N_W-1:0]    KAP_POS_MAX   = 56'h10000;
   localparam logic [DIV_N_W-1:0]    KAP_NEG_MAX   = 56'h20000;
   localparam logic [KAP_W-1:0]      KAP_NEG_SAT   = 18'h20000;
   localparam logic [SQ_W-1:0]       SQ_BIT_INIT   = 32'h4000_0000;

   typedef enum logic [1:0] {
      ACT_CLEAR = 2'd0,
      ACT_INC   = 2'd1,
      ACT_QUERY = 2'd2
   } action_type;

endpackage

/* rtl/core/cma_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cma_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/confusion_matrix_accuracy.sv */
// Confusion matrix accumulator with per-class accuracies, standard errors and kappa.
// Depends on cma_pkg, cma_ram and confusion_matrix_accuracy_macros.svh.
//
// Usage:
//  - Input word is taken when start is high and busy is low. req_action selects
//    clear, increment (req_ref_index row, req_class_index column, req_increment_amount)
//    or query (req_class_index is the class reported).
//  - Clear drops the per-cell valid bits at once; busy stays low.
//  - Increment is a read-modify-write of the count RAM through S_INC_RD and S_INC_WR.
//  - Query walks the n x n matrix (read, then accumulate, per cell), then runs a shared
//    56-step restoring divider and a 16-step square root for each fraction and
//    standard error, and two divisions per class for chance agreement.
//  - The query result is on the rsp_ ports for one cycle with rsp_valid high;
//    the receiver cannot stall and there is no output backpressure.
//  - csr_wdata sets class_count; csr_ready is always high, write only while idle.
//  - Reset (synchronous) zeroes all cells and sets class_count to 16.
module confusion_matrix_accuracy (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [1:0]                          req_action,
   input  logic [cma_pkg::IDX_W-1:0]           req_ref_index,
   input  logic [cma_pkg::IDX_W-1:0]           req_class_index,
   input  logic [cma_pkg::AMT_W-1:0]           req_increment_amount,
   output logic                                rsp_valid,
   output logic [cma_pkg::Q_W-1:0]             rsp_producer_acc,
   output logic [cma_pkg::Q_W-1:0]             rsp_producer_se,
   output logic [cma_pkg::Q_W-1:0]             rsp_user_acc,
   output logic [cma_pkg::Q_W-1:0]             rsp_user_se,
   output logic [cma_pkg::Q_W-1:0]             rsp_overall_acc,
   output logic [cma_pkg::Q_W-1:0]             rsp_overall_se,
   output logic signed [cma_pkg::KAP_W-1:0]    rsp_kappa_value,
   output logic [cma_pkg::ROW_W-1:0]           rsp_row_total,
   output logic [cma_pkg::ROW_W-1:0]           rsp_column_total,
   output logic [cma_pkg::TOT_W-1:0]           rsp_grand_total,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [cma_pkg::CFG_W-1:0]           csr_wdata
);

`include "confusion_matrix_accuracy_macros.svh"

   typedef enum logic [3:0] {
      S_IDLE, S_INC_RD, S_INC_WR, S_WALK_RD, S_WALK_ACC, S_SEL, S_FRAC_SETUP, S_DIV,
      S_DIV_END, S_FRAC_END, S_SE_SETUP, S_SQRT, S_SE_END, S_PE_MUL, S_KAP_SETUP
   } state_type;

   typedef enum logic [2:0] {J_PA, J_UA, J_OA, J_RI, J_CI} job_type;
   typedef enum logic [1:0] {M_FRAC, M_SE, M_KAP} mode_type;

   localparam int IW = cma_pkg::IDX_W;
   localparam int CW = cma_pkg::COUNT_BITS;
   localparam int RW = cma_pkg::ROW_W;
   localparam int TW = cma_pkg::TOT_W;
   localparam int QW = cma_pkg::Q_W;
   localparam int NW = cma_pkg::DIV_N_W;

   state_type             state_ff;
   job_type               job_ff;
   mode_type              mode_ff;
   logic [cma_pkg::CFG_W-1:0] classes_ff;
   logic [cma_pkg::DEPTH-1:0] valid_ff;
   logic [IW-1:0]         i_ff, j_ff, ci_ff;
   logic [cma_pkg::AMT_W-1:0] amt_ff;
   logic [RW-1:0]         rows_ff [cma_pkg::MAX_CLASSES];
   logic [RW-1:0]         cols_ff [cma_pkg::MAX_CLASSES];
   logic [RW-1:0]         row_acc_ff, rt_ff, ct_ff;
   logic [TW-1:0]         total_ff, trace_ff;
   logic [CW-1:0]         diag_ff;
   logic [NW-1:0]         n_ff;
   logic [TW-1:0]         r_ff, d_ff;
   logic [cma_pkg::DIV_CNT_W-1:0] div_cnt_ff;
   logic [cma_pkg::SQ_W-1:0] sq_v_ff, sq_res_ff, sq_bit_ff;
   logic [cma_pkg::SQ_CNT_W-1:0] sq_cnt_ff;
   logic [QW-1:0]         frac_ff, fr_ff, fc_ff;
   logic [cma_pkg::PE_W-1:0] pe_ff;
   logic                  rsp_valid_ff;
   logic [QW-1:0]         pa_ff, pse_ff, ua_ff, use_ff, oa_ff, ose_ff;
   logic [cma_pkg::KAP_W-1:0] kap_ff;

   // class count clamp
   logic [cma_pkg::CFG_W-1:0] n_eff;
   logic [IW-1:0]         n_m1;
   always_comb begin
      n_eff = classes_ff;
      if (classes_ff == '0) begin
         n_eff = cma_pkg::CFG_W'(1);
      end else if (classes_ff > cma_pkg::CFG_W'(cma_pkg::MAX_CLASSES)) begin
         n_eff = cma_pkg::CFG_W'(cma_pkg::MAX_CLASSES);
      end
      n_m1 = IW'(n_eff - cma_pkg::CFG_W'(1));
   end

   // count RAM
   logic [cma_pkg::ADDR_W-1:0] addr;
   logic [CW-1:0]         ram_rdata, cell_val, wr_data;
   logic                  wr_en;
   logic [CW:0]           inc_sum;

   assign addr     = {i_ff, j_ff};
   assign cell_val = valid_ff[addr] ? ram_rdata : '0;
   assign inc_sum  = {1'b0, cell_val} + (CW+1)'(amt_ff);
   assign wr_data  = inc_sum[CW] ? cma_pkg::CELL_MAX : inc_sum[CW-1:0];
   assign wr_en    = (state_ff == S_INC_WR);

   cma_ram #(.WIDTH(CW), .DEPTH(cma_pkg::DEPTH)) u_count_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (addr),
      .wr_data (wr_data),
      .rd_addr (addr),
      .rd_data (ram_rdata)
   );

   // row/column total read ports
   logic [IW-1:0] row_idx, col_idx;
   logic [RW-1:0] row_rd, col_rd;
   assign row_idx = (state_ff == S_SEL) ? ci_ff : i_ff;
   assign col_idx = (state_ff == S_SEL) ? ci_ff :
                    (state_ff == S_WALK_ACC) ? j_ff : i_ff;
   assign row_rd  = rows_ff[row_idx];
   assign col_rd  = cols_ff[col_idx];

   // walk accumulation
   logic [RW-1:0] row_sum, col_sum;
   assign row_sum = row_acc_ff + RW'(cell_val);
   assign col_sum = ((i_ff == '0) ? '0 : col_rd) + RW'(cell_val);

   // divider step
   logic [TW:0]   div_rs;
   logic          div_ge;
   logic [TW-1:0] div_r_next;
   logic          round_up;
   assign div_rs     = {r_ff, n_ff[NW-1]};
   assign div_ge     = div_rs >= {1'b0, d_ff};
   assign div_r_next = div_ge ? TW'(div_rs - {1'b0, d_ff}) : div_rs[TW-1:0];
   assign round_up   = {r_ff, 1'b0} >= {1'b0, d_ff};

   // square root step
   logic [cma_pkg::SQ_W-1:0] sq_t;
   assign sq_t = sq_res_ff + sq_bit_ff;

   // fraction operands
   logic [TW-1:0] fa, fb;
   always_comb begin
      case (job_ff)
         J_PA:    begin fa = TW'(diag_ff);  fb = TW'(rt_ff);  end
         J_UA:    begin fa = TW'(diag_ff);  fb = TW'(ct_ff);  end
         J_OA:    begin fa = trace_ff;      fb = total_ff;    end
         J_RI:    begin fa = TW'(row_rd);   fb = total_ff;    end
         J_CI:    begin fa = TW'(col_rd);   fb = total_ff;    end
         default: begin fa = '0;            fb = '0;          end
      endcase
   end

   // standard error operands
   logic [TW-1:0] sd, st;
   logic [QW-1:0] sp;
   logic [2*QW-1:0] se_prod;
   always_comb begin
      case (job_ff)
         J_PA:    begin sd = TW'(diag_ff); st = TW'(rt_ff); sp = pa_ff; end
         J_UA:    begin sd = TW'(diag_ff); st = TW'(ct_ff); sp = ua_ff; end
         J_OA:    begin sd = trace_ff;     st = total_ff;   sp = oa_ff; end
         default: begin sd = '0;           st = '0;         sp = '0;    end
      endcase
      se_prod = sp * (cma_pkg::ONE_Q16 - sp);
   end

   // kappa setup
   logic [32:0] pc, pe33, den, kdiff;
   logic        kneg;
   assign pc    = {oa_ff, 16'b0};
   assign pe33  = {1'b0, pe_ff[31:0]};
   assign den   = 33'h1_0000_0000 - pe33;
   assign kneg  = pc < pe33;
   assign kdiff = kneg ? (pe33 - pc) : (pc - pe33);

   logic [2*QW-1:0] pe_prod;
   assign pe_prod = fr_ff * fc_ff;

   logic accept;
   assign accept = start && (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         classes_ff   <= cma_pkg::CLASSES_RESET;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         job_ff       <= J_PA;
         mode_ff      <= M_FRAC;
      end else begin
         if (csr_valid) begin
            classes_ff <= csr_wdata;
         end
         case (state_ff)
            S_IDLE: begin
               rsp_valid_ff <= 1'b0;
               if (accept) begin
                  amt_ff <= req_increment_amount;
                  ci_ff  <= req_class_index;
                  if (req_action == cma_pkg::ACT_QUERY) begin
                     i_ff <= '0;
                     j_ff <= '0;
                  end else begin
                     i_ff <= req_ref_index;
                     j_ff <= req_class_index;
                  end
                  if (req_action == cma_pkg::ACT_CLEAR) begin
                     valid_ff <= '0;
                  end else if (req_action == cma_pkg::ACT_INC) begin
                     if ({1'b0, req_ref_index} < n_eff && {1'b0, req_class_index} < n_eff)
                     begin
                        state_ff <= S_INC_RD;
                     end
                  end else if (req_action == cma_pkg::ACT_QUERY) begin
                     total_ff   <= '0;
                     trace_ff   <= '0;
                     diag_ff    <= '0;
                     row_acc_ff <= '0;
                     state_ff   <= S_WALK_RD;
                  end
               end
            end
            S_INC_RD: state_ff <= S_INC_WR;
            S_INC_WR: begin
               valid_ff[addr] <= 1'b1;
               state_ff       <= S_IDLE;
            end
            S_WALK_RD: state_ff <= S_WALK_ACC;
            S_WALK_ACC: begin
               cols_ff[j_ff] <= col_sum;
               total_ff      <= total_ff + TW'(cell_val);
               if (i_ff == j_ff) begin
                  trace_ff <= trace_ff + TW'(cell_val);
               end
               if (i_ff == ci_ff && j_ff == ci_ff) begin
                  diag_ff <= cell_val;
               end
               if (j_ff == n_m1) begin
                  rows_ff[i_ff] <= row_sum;
                  row_acc_ff    <= '0;
                  j_ff          <= '0;
                  if (i_ff == n_m1) begin
                     state_ff <= S_SEL;
                  end else begin
                     i_ff     <= i_ff + IW'(1);
                     state_ff <= S_WALK_RD;
                  end
               end else begin
                  row_acc_ff <= row_sum;
                  j_ff       <= j_ff + IW'(1);
                  state_ff   <= S_WALK_RD;
               end
            end
            S_SEL: begin
               if ({1'b0, ci_ff} < n_eff) begin
                  rt_ff <= row_rd;
                  ct_ff <= col_rd;
               end else begin
                  rt_ff <= '0;
                  ct_ff <= '0;
               end
               job_ff   <= J_PA;
               state_ff <= S_FRAC_SETUP;
            end
            S_FRAC_SETUP: begin
               if (fb == '0) begin
                  frac_ff  <= '0;
                  state_ff <= S_FRAC_END;
               end else if (fa >= fb) begin
                  frac_ff  <= cma_pkg::ONE_Q16;
                  state_ff <= S_FRAC_END;
               end else begin
                  n_ff       <= {fa, 16'b0};
                  d_ff       <= fb;
                  r_ff       <= '0;
                  div_cnt_ff <= '0;
                  mode_ff    <= M_FRAC;
                  state_ff   <= S_DIV;
               end
            end
            S_DIV: begin
               r_ff       <= div_r_next;
               n_ff       <= {n_ff[NW-2:0], div_ge};
               div_cnt_ff <= div_cnt_ff + cma_pkg::DIV_CNT_W'(1);
               if (div_cnt_ff == cma_pkg::DIV_CNT_W'(NW - 1)) begin
                  state_ff <= S_DIV_END;
               end
            end
            S_DIV_END: begin
               case (mode_ff)
                  M_FRAC: begin
                     frac_ff  <= n_ff[QW-1:0] + QW'(round_up);
                     state_ff <= S_FRAC_END;
                  end
                  M_SE: begin
                     sq_v_ff   <= n_ff[cma_pkg::SQ_W-1:0];
                     sq_res_ff <= '0;
                     sq_bit_ff <= cma_pkg::SQ_BIT_INIT;
                     sq_cnt_ff <= '0;
                     state_ff  <= S_SQRT;
                  end
                  M_KAP: begin
                     if (kneg) begin
                        kap_ff <= (n_ff > cma_pkg::KAP_NEG_MAX) ? cma_pkg::KAP_NEG_SAT :
                                  cma_pkg::KAP_W'(-n_ff[cma_pkg::KAP_W-1:0]);
                     end else begin
                        kap_ff <= (n_ff > cma_pkg::KAP_POS_MAX) ?
                                  cma_pkg::KAP_W'(cma_pkg::ONE_Q16) :
                                  n_ff[cma_pkg::KAP_W-1:0];
                     end
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= S_IDLE;
                  end
                  default: state_ff <= S_IDLE;
               endcase
            end
            S_FRAC_END: begin
               case (job_ff)
                  J_PA:    begin pa_ff <= frac_ff; state_ff <= S_SE_SETUP; end
                  J_UA:    begin ua_ff <= frac_ff; state_ff <= S_SE_SETUP; end
                  J_OA:    begin oa_ff <= frac_ff; state_ff <= S_SE_SETUP; end
                  J_RI: begin
                     fr_ff    <= frac_ff;
                     job_ff   <= J_CI;
                     state_ff <= S_FRAC_SETUP;
                  end
                  default: begin fc_ff <= frac_ff; state_ff <= S_PE_MUL; end
               endcase
            end
            S_SE_SETUP: begin
               if (sd == '0 || sd >= st) begin
                  sq_res_ff <= '0;
                  state_ff  <= S_SE_END;
               end else begin
                  n_ff       <= NW'(se_prod);
                  d_ff       <= st - TW'(1);
                  r_ff       <= '0;
                  div_cnt_ff <= '0;
                  mode_ff    <= M_SE;
                  state_ff   <= S_DIV;
               end
            end
            S_SQRT: begin
               if (sq_v_ff >= sq_t) begin
                  sq_v_ff   <= sq_v_ff - sq_t;
                  sq_res_ff <= (sq_res_ff >> 1) + sq_bit_ff;
               end else begin
                  sq_res_ff <= sq_res_ff >> 1;
               end
               sq_bit_ff <= sq_bit_ff >> 2;
               sq_cnt_ff <= sq_cnt_ff + cma_pkg::SQ_CNT_W'(1);
               if (sq_cnt_ff == '1) begin
                  state_ff <= S_SE_END;
               end
            end
            S_SE_END: begin
               case (job_ff)
                  J_PA: begin
                     pse_ff   <= sq_res_ff[QW-1:0];
                     job_ff   <= J_UA;
                     state_ff <= S_FRAC_SETUP;
                  end
                  J_UA: begin
                     use_ff   <= sq_res_ff[QW-1:0];
                     job_ff   <= J_OA;
                     state_ff <= S_FRAC_SETUP;
                  end
                  default: begin
                     ose_ff <= sq_res_ff[QW-1:0];
                     if (total_ff == '0) begin
                        kap_ff       <= '0;
                        rsp_valid_ff <= 1'b1;
                        state_ff     <= S_IDLE;
                     end else begin
                        i_ff     <= '0;
                        pe_ff    <= '0;
                        job_ff   <= J_RI;
                        state_ff <= S_FRAC_SETUP;
                     end
                  end
               endcase
            end
            S_PE_MUL: begin
               pe_ff <= pe_ff + cma_pkg::PE_W'(pe_prod);
               if (i_ff == n_m1) begin
                  state_ff <= S_KAP_SETUP;
               end else begin
                  i_ff     <= i_ff + IW'(1);
                  job_ff   <= J_RI;
                  state_ff <= S_FRAC_SETUP;
               end
            end
            S_KAP_SETUP: begin
               if (pe_ff[cma_pkg::PE_W-1:32] != '0) begin
                  kap_ff       <= '0;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end else begin
                  n_ff       <= {7'b0, kdiff, 16'b0} + {24'b0, den[32:1]};
                  d_ff       <= TW'(den);
                  r_ff       <= '0;
                  div_cnt_ff <= '0;
                  mode_ff    <= M_KAP;
                  state_ff   <= S_DIV;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy             = (state_ff != S_IDLE);
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_producer_acc = pa_ff;
   assign rsp_producer_se  = pse_ff;
   assign rsp_user_acc     = ua_ff;
   assign rsp_user_se      = use_ff;
   assign rsp_overall_acc  = oa_ff;
   assign rsp_overall_se   = ose_ff;
   assign rsp_kappa_value  = kap_ff;
   assign rsp_row_total    = rt_ff;
   assign rsp_column_total = ct_ff;
   assign rsp_grand_total  = total_ff;

   `CMA_ASSERT_NEXT(a_strobe_pulse, clock, reset, rsp_valid, !rsp_valid)
   `CMA_ASSERT_SAME(a_rsp_when_idle, clock, reset, rsp_valid, !busy)
   `CMA_ASSERT_NEXT(a_query_busy, clock, reset,
      start && !busy && req_action == cma_pkg::ACT_QUERY, busy)
   `CMA_ASSERT_SAME(a_div_nonzero, clock, reset, state_ff == S_DIV, d_ff != '0)
   `CMA_ASSERT_SAME(a_frac_range, clock, reset, rsp_valid,
      rsp_producer_acc <= cma_pkg::ONE_Q16 && rsp_user_acc <= cma_pkg::ONE_Q16 &&
      rsp_overall_acc <= cma_pkg::ONE_Q16)

endmodule
